// ===== design/dns_message_parser_top_assert.svh =====
// Assertion macros used by the checker file of the parser.
`ifndef DNS_MESSAGE_PARSER_TOP_ASSERT_SVH
`define DNS_MESSAGE_PARSER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNSMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dns parser check failed");

// Consequent must hold in the cycle after the antecedent.
`define DNSMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dns parser check failed");

`endif

// ===== design/dnsmp_pkg.sv =====
package dnsmp_pkg;

    localparam int unsigned HeaderBytes      = 12;
    localparam int unsigned HeaderWordBytes  = 8;
    localparam int unsigned QtcBytes         = 4;
    localparam int unsigned AnswerFixedBytes = 12;
    localparam int unsigned TtlFirstByte     = 6;
    localparam int unsigned RdlenFirstByte   = 10;

    localparam logic [15:0] TypeAaaa         = 16'd28;
    localparam logic [6:0]  MaxLabelsReset   = 7'd127;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EARLY  = 2'd1,
        ST_LABELS = 2'd2
    } t_status;

endpackage

// ===== design/dns_message_parser_top.sv =====
// DNS message parser for a TCP-framed byte stream.
// The input channel (i_in_valid / o_in_ready / i_data_byte) takes one byte
// per item: a two-byte big-endian length, then that many message bytes.
// The parser pulls the header words, counts question name labels up to
// the max_labels register, takes qtype/qclass and the first answer's TTL
// and rdlength, and skips the rdata. Bytes after that are ignored.
// One result item leaves on o_out_valid / i_out_ready when the framed
// length is used up, or right after the low length byte if it is zero.
// Throughput is one byte per cycle while o_in_ready is high; each byte only
// advances counters and shifts one field register. The result is shown from
// the result register in the cycle after a message's last byte is accepted.
// If the receiver stalls, the parser keeps taking bytes; only a byte that
// would finish a message waits while the result register is still full.
// Synchronous active-low reset returns the parser to waiting for a length
// prefix, empties the result register and sets max_labels to 127.
// i_cfg_wr_en writes max_labels from i_cfg_wr_data in the same cycle.
module dns_message_parser_top
    import dnsmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_message_id,
    output logic [15:0] o_header_flags,
    output logic [15:0] o_question_count,
    output logic [15:0] o_answer_count,
    output logic [6:0]  o_label_total,
    output logic [15:0] o_query_type,
    output logic [15:0] o_query_class,
    output logic        o_is_aaaa,
    output logic [31:0] o_answer_ttl,
    output logic [15:0] o_answer_data_length,
    output logic [15:0] o_framed_length,
    output logic [1:0]  o_parse_status
);

    typedef enum logic [3:0] {
        PH_LEN_HI    = 4'd0,
        PH_LEN_LO    = 4'd1,
        PH_HEADER    = 4'd2,
        PH_NAME_LEN  = 4'd3,
        PH_NAME_DATA = 4'd4,
        PH_QTC       = 4'd5,
        PH_ANSWER    = 4'd6,
        PH_SKIP      = 4'd7,
        PH_DONE      = 4'd8
    } t_phase;

    t_phase      r_phase, n_phase, step_phase;
    logic [6:0]  r_max_labels;
    logic [15:0] r_msg_len, n_msg_len;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [3:0]  r_fpos, n_fpos;
    logic [7:0]  r_lbl_left, n_lbl_left;
    logic [6:0]  r_lbl_cnt, n_lbl_cnt;
    logic [15:0] r_id, n_id, r_flags, n_flags, r_qdcount, n_qdcount, r_ancount, n_ancount;
    logic [15:0] r_qtype, n_qtype, r_qclass, n_qclass;
    logic [31:0] r_ttl, n_ttl;
    logic [15:0] r_rdlen, n_rdlen;
    logic [15:0] r_skip, n_skip;
    logic        r_too_many, n_too_many;
    logic        emit;
    t_status     n_status;
    logic        in_acc;

    logic        r_out_valid;
    logic [15:0] r_o_id, r_o_flags, r_o_qdcount, r_o_ancount, r_o_qtype, r_o_qclass;
    logic [6:0]  r_o_lbl;
    logic        r_o_aaaa;
    logic [31:0] r_o_ttl;
    logic [15:0] r_o_rdlen, r_o_len;
    t_status     r_o_status;

    // Next state for one accepted byte.
    always_comb begin
        n_msg_len    = r_msg_len;
        n_bytes_left = r_bytes_left;
        n_fpos       = r_fpos;
        n_lbl_left   = r_lbl_left;
        n_lbl_cnt    = r_lbl_cnt;
        n_id         = r_id;
        n_flags      = r_flags;
        n_qdcount    = r_qdcount;
        n_ancount    = r_ancount;
        n_qtype      = r_qtype;
        n_qclass     = r_qclass;
        n_ttl        = r_ttl;
        n_rdlen      = r_rdlen;
        n_skip       = r_skip;
        n_too_many   = r_too_many;
        step_phase   = r_phase;
        emit         = 1'b0;

        unique case (r_phase)
            PH_LEN_HI: begin
                n_msg_len  = {i_data_byte, 8'h00};
                step_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_msg_len    = {r_msg_len[15:8], i_data_byte};
                n_bytes_left = n_msg_len;
                n_fpos       = '0;
                n_lbl_left   = '0;
                n_lbl_cnt    = '0;
                n_id         = '0;
                n_flags      = '0;
                n_qdcount    = '0;
                n_ancount    = '0;
                n_qtype      = '0;
                n_qclass     = '0;
                n_ttl        = '0;
                n_rdlen      = '0;
                n_skip       = '0;
                n_too_many   = 1'b0;
                step_phase   = PH_HEADER;
            end
            PH_HEADER: begin
                if (r_fpos < 4'(HeaderWordBytes)) begin
                    unique case (r_fpos[2:1])
                        2'd0: n_id      = {r_id[7:0], i_data_byte};
                        2'd1: n_flags   = {r_flags[7:0], i_data_byte};
                        2'd2: n_qdcount = {r_qdcount[7:0], i_data_byte};
                        2'd3: n_ancount = {r_ancount[7:0], i_data_byte};
                        default: ;
                    endcase
                end
                n_fpos = r_fpos + 4'd1;
                if (n_fpos == 4'(HeaderBytes)) begin
                    n_fpos     = '0;
                    step_phase = PH_NAME_LEN;
                end
            end
            PH_NAME_LEN: begin
                priority if (i_data_byte == 8'd0) begin
                    n_fpos     = '0;
                    step_phase = PH_QTC;
                end else if (r_lbl_cnt >= r_max_labels) begin
                    n_too_many = 1'b1;
                    step_phase = PH_DONE;
                end else begin
                    n_lbl_cnt  = r_lbl_cnt + 7'd1;
                    n_lbl_left = i_data_byte;
                    step_phase = PH_NAME_DATA;
                end
            end
            PH_NAME_DATA: begin
                n_lbl_left = r_lbl_left - 8'd1;
                if (n_lbl_left == 8'd0) begin
                    step_phase = PH_NAME_LEN;
                end
            end
            PH_QTC: begin
                if (r_fpos[1]) begin
                    n_qclass = {r_qclass[7:0], i_data_byte};
                end else begin
                    n_qtype = {r_qtype[7:0], i_data_byte};
                end
                n_fpos = r_fpos + 4'd1;
                if (n_fpos == 4'(QtcBytes)) begin
                    n_fpos     = '0;
                    step_phase = (r_ancount != 16'd0) ? PH_ANSWER : PH_DONE;
                end
            end
            PH_ANSWER: begin
                priority if (r_fpos >= 4'(RdlenFirstByte)) begin
                    n_rdlen = {r_rdlen[7:0], i_data_byte};
                end else if (r_fpos >= 4'(TtlFirstByte)) begin
                    n_ttl = {r_ttl[23:0], i_data_byte};
                end
                n_fpos = r_fpos + 4'd1;
                if (n_fpos == 4'(AnswerFixedBytes)) begin
                    n_fpos = '0;
                    if (n_rdlen == 16'd0) begin
                        step_phase = PH_DONE;
                    end else begin
                        n_skip     = n_rdlen;
                        step_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    step_phase = PH_DONE;
                end
            end
            default: ;
        endcase

        // The label overflow wins; otherwise the message is complete only
        // if parsing reached its end by the time the framed length ran out.
        if (n_too_many) begin
            n_status = ST_LABELS;
        end else if (step_phase == PH_DONE) begin
            n_status = ST_OK;
        end else begin
            n_status = ST_EARLY;
        end

        n_phase = step_phase;
        if (r_phase == PH_LEN_LO) begin
            if (n_msg_len == 16'd0) begin
                emit    = 1'b1;
                n_phase = PH_LEN_HI;
            end
        end else if (r_phase != PH_LEN_HI) begin
            n_bytes_left = r_bytes_left - 16'd1;
            if (r_bytes_left == 16'd1) begin
                emit    = 1'b1;
                n_phase = PH_LEN_HI;
            end
        end
    end

    assign o_in_ready = !(emit && r_out_valid && !i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEN_HI;
            r_max_labels <= MaxLabelsReset;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_labels <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_phase <= n_phase;
            end
            if (in_acc && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (in_acc) begin
            r_msg_len    <= n_msg_len;
            r_bytes_left <= n_bytes_left;
            r_fpos       <= n_fpos;
            r_lbl_left   <= n_lbl_left;
            r_lbl_cnt    <= n_lbl_cnt;
            r_id         <= n_id;
            r_flags      <= n_flags;
            r_qdcount    <= n_qdcount;
            r_ancount    <= n_ancount;
            r_qtype      <= n_qtype;
            r_qclass     <= n_qclass;
            r_ttl        <= n_ttl;
            r_rdlen      <= n_rdlen;
            r_skip       <= n_skip;
            r_too_many   <= n_too_many;
        end

        if (in_acc && emit) begin
            r_o_id      <= n_id;
            r_o_flags   <= n_flags;
            r_o_qdcount <= n_qdcount;
            r_o_ancount <= n_ancount;
            r_o_lbl     <= n_lbl_cnt;
            r_o_qtype   <= n_qtype;
            r_o_qclass  <= n_qclass;
            r_o_aaaa    <= (n_qtype == TypeAaaa);
            r_o_ttl     <= n_ttl;
            r_o_rdlen   <= n_rdlen;
            r_o_len     <= n_msg_len;
            r_o_status  <= n_status;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_message_id         = r_o_id;
    assign o_header_flags       = r_o_flags;
    assign o_question_count     = r_o_qdcount;
    assign o_answer_count       = r_o_ancount;
    assign o_label_total        = r_o_lbl;
    assign o_query_type         = r_o_qtype;
    assign o_query_class        = r_o_qclass;
    assign o_is_aaaa            = r_o_aaaa;
    assign o_answer_ttl         = r_o_ttl;
    assign o_answer_data_length = r_o_rdlen;
    assign o_framed_length      = r_o_len;
    assign o_parse_status       = r_o_status;

endmodule

// ===== design/dnsmp_checker.sv =====
`include "dns_message_parser_top_assert.svh"

module dnsmp_checker
    import dnsmp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_answer_count,
    input logic [31:0] o_answer_ttl,
    input logic [15:0] o_answer_data_length,
    input logic [15:0] o_framed_length,
    input logic [1:0]  o_parse_status
);

    // A stalled result stays in place.
    `DNSMP_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_framed_length) && $stable(o_parse_status))

    // The input side waits only behind a full, stalled result register.
    `DNSMP_ASSERT_NOW(a_in_stall_cause, !o_in_ready, o_out_valid && !i_out_ready)

    // An empty message can never parse cleanly.
    `DNSMP_ASSERT_NOW(a_empty_early, o_out_valid && o_framed_length == 16'd0, o_parse_status == ST_EARLY)

    // Answer fields are only filled when the header announced answers.
    `DNSMP_ASSERT_NOW(a_no_answer, o_out_valid && o_answer_count == 16'd0, o_answer_ttl == 32'd0 && o_answer_data_length == 16'd0)

endmodule

bind dns_message_parser_top dnsmp_checker u_dnsmp_checker (.*);
